@@ src/cmse_pkg.sv @@
package cmse_pkg;

  // input request fields
  typedef struct packed {
    logic [7:0]         cap_byte;
    logic               first;
    logic               final_req;
    logic signed [15:0] col_value;
    logic signed [15:0] line_value;
  } in_item_t;

  // result request fields
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       item_last;
    logic       string_done;
    logic       error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic dig_emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dec_go;
    logic dig_last;
  } dp_sts_t;

  // escape modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_PCT  = 2'd1;
  localparam logic [1:0] MODE_PLUS = 2'd2;
  localparam logic [1:0] MODE_HALT = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_I    = 8'h69;

  localparam logic signed [16:0] VALUE_MAX = 17'sd65535;

  // multiples of each decimal weight, by digit position
  localparam logic [16:0] DEC_MULT [0:4][0:9] = '{
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700, 17'd800,
      17'd900},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000, 17'd7000,
      17'd8000, 17'd9000},
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000,
      17'd70000, 17'd80000, 17'd90000}
  };

  // saturating increment
  function automatic logic signed [16:0] bump(input logic signed [16:0] v);
    bump = (v >= VALUE_MAX) ? VALUE_MAX : v + 17'sd1;
  endfunction

endpackage

@@ src/cmse_ctl.sv @@
module cmse_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cmse_pkg::dp_sts_t  sts,
  output cmse_pkg::ctl_cmd_t cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DIGIT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // output register can take a new request this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // command decode and next state
  always_comb begin
    state_nxt    = state_r;
    cmd.take     = 1'b0;
    cmd.dig_emit = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !slot_free;
        cmd.take = in_valid && slot_free;
        if (cmd.take && sts.dec_go) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd.dig_emit = slot_free;
        if (slot_free && sts.dig_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if ((cmd.take && !sts.dec_go) || cmd.dig_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/cmse_dp.sv @@
module cmse_dp #(
  parameter int MAX_OUT = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmse_pkg::ctl_cmd_t  cmd,
  output cmse_pkg::dp_sts_t   sts,
  input  cmse_pkg::in_item_t  in_data,
  output cmse_pkg::out_item_t out_data
);

  localparam int CW = $clog2(MAX_OUT + 1);

  logic [1:0]         mode_r;
  logic signed [16:0] cur_r;
  logic signed [16:0] oth_r;
  logic [CW-1:0]      cnt_r;
  logic               failed_r;

  logic [15:0]         dval_r;
  logic [2:0]          dpos_r;
  logic                fin_r;
  cmse_pkg::out_item_t out_r;

  // effective state after a string start
  logic [1:0]         mode_e;
  logic signed [16:0] cur_e;
  logic signed [16:0] oth_e;
  logic [CW-1:0]      cnt_e;
  logic               fail_e;
  logic               room;

  logic [1:0]         mode_nxt;
  logic signed [16:0] cur_nxt;
  logic signed [16:0] oth_nxt;
  logic               fail_nxt;
  logic               emit;
  logic [7:0]         byte_v;
  logic               dec_go;

  logic [15:0] dec_u;
  logic [2:0]  dec_pos;
  logic [3:0]  dig;
  logic [16:0] dig_sub;

  always_comb begin
    if (in_data.first) begin
      mode_e = cmse_pkg::MODE_NONE;
      cur_e  = {in_data.line_value[15], in_data.line_value};
      oth_e  = {in_data.col_value[15], in_data.col_value};
      cnt_e  = '0;
      fail_e = 1'b0;
    end else begin
      mode_e = mode_r;
      cur_e  = cur_r;
      oth_e  = oth_r;
      cnt_e  = cnt_r;
      fail_e = failed_r;
    end
  end

  assign room = cnt_e < CW'(MAX_OUT);

  // escape decode for one capability byte
  always_comb begin
    mode_nxt = mode_e;
    cur_nxt  = cur_e;
    oth_nxt  = oth_e;
    fail_nxt = fail_e;
    emit     = 1'b0;
    byte_v   = '0;
    dec_go   = 1'b0;
    case (mode_e)
      cmse_pkg::MODE_NONE: begin
        if (!room || in_data.cap_byte == cmse_pkg::CH_NUL) begin
          mode_nxt = cmse_pkg::MODE_HALT;
        end else if (in_data.cap_byte == cmse_pkg::CH_PCT) begin
          mode_nxt = cmse_pkg::MODE_PCT;
        end else begin
          emit   = 1'b1;
          byte_v = in_data.cap_byte;
        end
      end
      cmse_pkg::MODE_PCT: begin
        mode_nxt = cmse_pkg::MODE_NONE;
        case (in_data.cap_byte)
          cmse_pkg::CH_D: begin
            cur_nxt = oth_e;
            dec_go  = room;
          end
          cmse_pkg::CH_I: begin
            oth_nxt = cmse_pkg::bump(oth_e);
            cur_nxt = cmse_pkg::bump(cur_e);
          end
          cmse_pkg::CH_PLUS: begin
            mode_nxt = cmse_pkg::MODE_PLUS;
          end
          cmse_pkg::CH_PCT: begin
            emit   = room;
            byte_v = cmse_pkg::CH_PCT;
          end
          default: begin
            fail_nxt = 1'b1;
            mode_nxt = cmse_pkg::MODE_HALT;
          end
        endcase
      end
      cmse_pkg::MODE_PLUS: begin
        if (in_data.cap_byte == cmse_pkg::CH_NUL) begin
          fail_nxt = 1'b1;
          mode_nxt = cmse_pkg::MODE_HALT;
        end else begin
          emit     = room;
          byte_v   = in_data.cap_byte + cur_e[7:0];
          cur_nxt  = oth_e;
          mode_nxt = cmse_pkg::MODE_NONE;
        end
      end
      default: begin
      end
    endcase
    // end of string
    if (in_data.final_req) begin
      if (mode_nxt == cmse_pkg::MODE_PCT || mode_nxt == cmse_pkg::MODE_PLUS) begin
        fail_nxt = 1'b1;
      end
      mode_nxt = cmse_pkg::MODE_HALT;
    end
  end

  // decimal start: clamp and leading digit position
  always_comb begin
    dec_u = cur_e[16] ? 16'd0 : cur_e[15:0];
    if (dec_u >= 16'd10000) begin
      dec_pos = 3'd4;
    end else if (dec_u >= 16'd1000) begin
      dec_pos = 3'd3;
    end else if (dec_u >= 16'd100) begin
      dec_pos = 3'd2;
    end else if (dec_u >= 16'd10) begin
      dec_pos = 3'd1;
    end else begin
      dec_pos = 3'd0;
    end
  end

  // one decimal digit from the remaining value
  always_comb begin
    dig = '0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, dval_r} >= cmse_pkg::DEC_MULT[dpos_r][k]) begin
        dig = 4'(k);
      end
    end
    dig_sub = cmse_pkg::DEC_MULT[dpos_r][dig];
  end

  assign sts.dec_go   = dec_go;
  assign sts.dig_last = (dpos_r == 3'd0) || (cnt_r >= CW'(MAX_OUT - 1));

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cmse_pkg::MODE_NONE;
      cur_r    <= '0;
      oth_r    <= '0;
      cnt_r    <= '0;
      failed_r <= 1'b0;
    end else if (cmd.take) begin
      mode_r   <= mode_nxt;
      cur_r    <= cur_nxt;
      oth_r    <= oth_nxt;
      cnt_r    <= cnt_e + CW'(emit);
      failed_r <= fail_nxt;
    end else if (cmd.dig_emit) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // digit registers and result payload; an empty result carries a zero byte
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dval_r <= dec_u;
      dpos_r <= dec_pos;
      fin_r  <= in_data.final_req;
      if (!dec_go) begin
        out_r.out_byte    <= emit ? byte_v : 8'd0;
        out_r.has_byte    <= emit;
        out_r.item_last   <= 1'b1;
        out_r.string_done <= in_data.final_req;
        out_r.error       <= fail_nxt;
      end
    end else if (cmd.dig_emit) begin
      dval_r            <= dval_r - dig_sub[15:0];
      dpos_r            <= dpos_r - 3'd1;
      out_r.out_byte    <= cmse_pkg::CH_ZERO + {4'd0, dig};
      out_r.has_byte    <= 1'b1;
      out_r.item_last   <= sts.dig_last;
      out_r.string_done <= sts.dig_last && fin_r;
      out_r.error       <= failed_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ src/cursor_motion_string_expander.sv @@
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------
// input    | in_valid  | in_stall  | in_data  (cmse_pkg::in_item_t)
// result   | out_valid | out_stall | out_data (cmse_pkg::out_item_t)
//
// plain bytes and escape bytes other than %d give one result each
// a %d gives one result for each of the n decimal digits that still fit (at most
// five; an empty result when the output is already full), one digit a cycle while
// the output is not stalled, from the digit extraction step in the datapath
// reset is synchronous; no memory, so no clearing pass
// a result waits in the output register while out_stall is high; the input
// stalls while that register is held or digits are still being produced
module cursor_motion_string_expander #(
  parameter int MAX_OUT = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmse_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmse_pkg::out_item_t out_data
);

  cmse_pkg::ctl_cmd_t cmd;
  cmse_pkg::dp_sts_t  sts;

  // sequencing and handshake
  cmse_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // escape decode, value state and digit generation
  cmse_dp #(
    .MAX_OUT (MAX_OUT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ src/cmse_checker.sv @@
module cmse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cmse_pkg::out_item_t out_data
);

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an empty result is the only result of its byte
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.item_last && out_data.out_byte == 8'd0)
    else $error("empty result not last or not zero");

  // end of string only on the last result of a byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |-> out_data.item_last)
    else $error("string_done without item_last");

  // the input is held off while a result sits stalled
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

endmodule

bind cursor_motion_string_expander cmse_checker u_cmse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

// predicts the expanded bytes of each request and checks them in order
class expansion_scoreboard;
  cmse_pkg::out_item_t expected_q[$];
  cmse_pkg::out_item_t step_q[$];
  logic [1:0] esc_mode;
  logic signed [16:0] cur_val;
  logic signed [16:0] col_val;
  logic [7:0] out_count;
  logic failed;
  int unsigned max_out;
  int request_count;
  int result_count;
  int string_count;
  int error_count;
  int full_count;
  int fail_count;

  function new(int unsigned limit);
    max_out = limit;
    esc_mode = cmse_pkg::MODE_NONE;
    cur_val = '0;
    col_val = '0;
    out_count = '0;
    failed = 1'b0;
    request_count = 0;
    result_count = 0;
    string_count = 0;
    error_count = 0;
    full_count = 0;
    fail_count = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // increment that sticks at the top of the 16-bit unsigned range
  function logic signed [16:0] inc_sat(logic signed [16:0] v);
    return (v >= cmse_pkg::VALUE_MAX) ? cmse_pkg::VALUE_MAX : v + 17'sd1;
  endfunction

  // one character out, unless the string is full or the step has no room
  function void put_char(logic [7:0] ch);
    cmse_pkg::out_item_t r;
    if (out_count < max_out && step_q.size() < 5) begin
      r = '0;
      r.out_byte = ch;
      r.has_byte = 1'b1;
      step_q.push_back(r);
      out_count++;
    end
  endfunction

  // decimal digits, most significant first; negative values print as 0
  function void put_decimal(logic signed [16:0] v);
    logic [16:0] mag;
    logic [7:0] digits[$];
    mag = v[16] ? 17'd0 : 17'(v);
    do begin
      digits.push_front(cmse_pkg::CH_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[k]) put_char(digits[k]);
  endfunction

  function void note_request(cmse_pkg::in_item_t req);
    request_count++;
    step_q.delete();
    // start of string: clear escape state and latch line and column
    if (req.first) begin
      string_count++;
      esc_mode = cmse_pkg::MODE_NONE;
      out_count = '0;
      failed = 1'b0;
      cur_val = {req.line_value[15], req.line_value};
      col_val = {req.col_value[15], req.col_value};
    end
    case (esc_mode)
      cmse_pkg::MODE_NONE: begin
        if (out_count >= max_out || req.cap_byte == cmse_pkg::CH_NUL) begin
          if (out_count >= max_out) full_count++;
          esc_mode = cmse_pkg::MODE_HALT;
        end else if (req.cap_byte == cmse_pkg::CH_PCT) begin
          esc_mode = cmse_pkg::MODE_PCT;
        end else begin
          put_char(req.cap_byte);
        end
      end
      cmse_pkg::MODE_PCT: begin
        esc_mode = cmse_pkg::MODE_NONE;
        case (req.cap_byte)
          cmse_pkg::CH_D: begin
            put_decimal(cur_val);
            cur_val = col_val;
          end
          cmse_pkg::CH_I: begin
            col_val = inc_sat(col_val);
            cur_val = inc_sat(cur_val);
          end
          cmse_pkg::CH_PLUS: esc_mode = cmse_pkg::MODE_PLUS;
          cmse_pkg::CH_PCT: put_char(cmse_pkg::CH_PCT);
          default: begin
            failed = 1'b1;
            esc_mode = cmse_pkg::MODE_HALT;
          end
        endcase
      end
      cmse_pkg::MODE_PLUS: begin
        if (req.cap_byte == cmse_pkg::CH_NUL) begin
          failed = 1'b1;
          esc_mode = cmse_pkg::MODE_HALT;
        end else begin
          put_char(req.cap_byte + cur_val[7:0]);
          cur_val = col_val;
          esc_mode = cmse_pkg::MODE_NONE;
        end
      end
      default: ;
    endcase
    // an escape still open on the last byte is malformed
    if (req.final_req) begin
      if (esc_mode == cmse_pkg::MODE_PCT || esc_mode == cmse_pkg::MODE_PLUS) failed = 1'b1;
      esc_mode = cmse_pkg::MODE_HALT;
      if (failed) error_count++;
    end
    // every request yields at least one result; flags go on the last one
    if (step_q.size() == 0) step_q.push_back('0);
    foreach (step_q[k]) step_q[k].error = failed;
    step_q[$].item_last = 1'b1;
    step_q[$].string_done = req.final_req;
    foreach (step_q[k]) expected_q.push_back(step_q[k]);
  endfunction

  function void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  function void check_result(cmse_pkg::out_item_t got);
    cmse_pkg::out_item_t want;
    result_count++;
    if (expected_q.size() == 0) begin
      fail_count++;
      $display("%0t: result %h arrived with nothing expected", $time, got);
      return;
    end
    want = expected_q.pop_front();
    check_field("out_byte", want.out_byte, got.out_byte);
    check_field("has_byte", want.has_byte, got.has_byte);
    check_field("item_last", want.item_last, got.item_last);
    check_field("string_done", want.string_done, got.string_done);
    check_field("error", want.error, got.error);
  endfunction
endclass

module testbench;
  localparam int MAX_OUT = 63;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cmse_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  cmse_pkg::out_item_t out_data;

  expansion_scoreboard sb = new(MAX_OUT);
  logic [7:0] cap_q[$];
  int burst_left;

  cursor_motion_string_expander #(
    .MAX_OUT(MAX_OUT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("timeout: run did not finish");
    $display("testbench NOT OK");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern, cycling through four styles
  initial begin
    int unsigned tick;
    int unsigned hold;
    tick = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case ((tick / 150) % 4)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 2) == 0);
        2: out_stall = ((tick % 7) < 3);
        default: begin
          if (hold == 0 && $urandom_range(0, 5) == 0) hold = $urandom_range(2, 9);
          out_stall = (hold != 0);
          if (hold != 0) hold--;
        end
      endcase
    end
  end

  // one request; senders work in bursts with gaps, except in steady stretches
  task automatic send_item(input cmse_pkg::in_item_t req);
    if (burst_left <= 0) begin
      if ((sb.request_count / 40) % 3 != 2) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_data = req;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) cap_q.push_back(s[i]);
  endtask

  // sends the queued capability bytes as one string
  task automatic send_cap(input logic signed [15:0] col, input logic signed [15:0] line,
                          input bit with_first, input bit with_final);
    cmse_pkg::in_item_t req;
    for (int i = 0; i < cap_q.size(); i++) begin
      req.cap_byte = cap_q[i];
      req.first = with_first && (i == 0);
      req.final_req = with_final && (i == cap_q.size() - 1);
      req.col_value = (i == 0) ? col : 16'($urandom);
      req.line_value = (i == 0) ? line : 16'($urandom);
      send_item(req);
    end
    cap_q.delete();
  endtask

  function automatic logic signed [15:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0, 1: rand_coord = 16'($urandom_range(0, 120));
      2: rand_coord = 16'($urandom);
      3: rand_coord = 16'sh7fff;
      4: rand_coord = 16'sh8000;
      default: rand_coord = -16'($urandom_range(1, 9));
    endcase
  endfunction

  // any byte except nul and the escape character
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == cmse_pkg::CH_PCT) b = cmse_pkg::CH_PLUS;
    return b;
  endfunction

  initial begin
    int random_count;
    int pick;
    int ntok;
    int first_pick;
    cmse_pkg::in_item_t req;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // string before any first byte: column and line are 0
    load_text("%d");
    send_cap(16'sd0, 16'sd0, 1'b0, 1'b1);
    // increment, five-digit value, then a negative column clamped to 0
    load_text("%i%d,%d");
    send_cap(-16'sd5, 16'sd32767, 1'b1, 1'b1);
    // offset character with a negative line, literal percent, largest column
    load_text("%+A%%%d");
    send_cap(16'sh7fff, -16'sd1, 1'b1, 1'b1);
    // unknown escape drops the rest of the string
    load_text("%qx");
    send_cap(rand_coord(), rand_coord(), 1'b1, 1'b1);
    // escape left open at the end of the string
    load_text("%");
    send_cap(16'sd0, 16'sd0, 1'b1, 1'b1);
    load_text("%+");
    send_cap(16'sh8000, 16'sd100, 1'b1, 1'b1);
    // nul ends the string early
    load_text("a");
    cap_q.push_back(cmse_pkg::CH_NUL);
    load_text("b");
    send_cap(16'sd1, 16'sd2, 1'b1, 1'b1);
    // byte after the end of a string with no new first
    load_text("z");
    send_cap(16'sd0, 16'sd0, 1'b0, 1'b0);
    // nul as the character of an offset escape
    load_text("%+");
    cap_q.push_back(cmse_pkg::CH_NUL);
    load_text("c");
    send_cap(16'sd3, 16'sd4, 1'b1, 1'b1);

    // random strings: mostly well formed, some overflowing, some noise
    random_count = 0;
    first_pick = 1;
    while (random_count < 100) begin
      pick = first_pick ? 100 : $urandom_range(0, 99);
      first_pick = 0;
      if (pick < 72) begin
        ntok = $urandom_range(1, 8);
        repeat (ntok) begin
          case ($urandom_range(0, 6))
            0, 1: cap_q.push_back(rand_plain());
            2: begin
              cap_q.push_back(cmse_pkg::CH_PCT);
              cap_q.push_back(cmse_pkg::CH_D);
            end
            3: begin
              cap_q.push_back(cmse_pkg::CH_PCT);
              cap_q.push_back(cmse_pkg::CH_I);
            end
            4: begin
              cap_q.push_back(cmse_pkg::CH_PCT);
              cap_q.push_back(cmse_pkg::CH_PLUS);
              cap_q.push_back(rand_plain());
            end
            5: begin
              cap_q.push_back(cmse_pkg::CH_PCT);
              cap_q.push_back(cmse_pkg::CH_PCT);
            end
            default: begin
              cap_q.push_back(cmse_pkg::CH_PCT);
              cap_q.push_back(8'($urandom));
            end
          endcase
        end
        random_count += cap_q.size();
        send_cap(rand_coord(), rand_coord(), 1'b1, 1'b1);
      end else if (pick < 76 || pick == 100) begin
        // long string that runs into the output limit at or near a %d
        repeat ($urandom_range(58, 64)) cap_q.push_back(rand_plain());
        cap_q.push_back(cmse_pkg::CH_PCT);
        cap_q.push_back(cmse_pkg::CH_D);
        load_text("xy");
        random_count += cap_q.size();
        send_cap(rand_coord(), 16'sh7fff, 1'b1, 1'b1);
      end else begin
        // noise: any byte, first and final anywhere
        repeat ($urandom_range(1, 6)) begin
          req.cap_byte = ($urandom_range(0, 3) == 0) ? cmse_pkg::CH_PCT : 8'($urandom);
          req.first = ($urandom_range(0, 3) == 0);
          req.final_req = ($urandom_range(0, 3) == 0);
          req.col_value = 16'($urandom);
          req.line_value = 16'($urandom);
          send_item(req);
          random_count++;
        end
      end
    end
    in_valid = 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d requests in %0d strings, %0d results checked",
             sb.request_count, sb.string_count, sb.result_count);
    $display("%0d strings ended in error, %0d halted on a full output",
             sb.error_count, sb.full_count);
    if (sb.fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
